[rtl/nps_pkg.sv]
// ----------------------------------------------------------------------------
// nps_pkg
// Shared constants and types for the nearest point search block.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int NPS_MAX_ENTRIES = 32768;
    localparam int NPS_COORD_BITS  = 16;
    localparam int NPS_COUNT_BITS  = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } nps_state_t;

    // Sideband that travels with each table entry through the distance pipe.
    typedef struct packed {
        logic valid;
        logic last;
    } nps_tag_t;

endpackage

[rtl/nearest_point_search.sv]
// ----------------------------------------------------------------------------
// nearest_point_search
// Linear-scan 2D nearest neighbor over a table of signed fixed-point points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries op, entry_index, coord_x,
//   coord_y. A load transfer (op = load) writes {x, y} into the table slot
//   entry_index and produces no result; slots at or above MAX_ENTRIES are
//   dropped. A query transfer scans slots 0 .. n-1, n = min(entry_count,
//   MAX_ENTRIES), and returns the lowest slot with the smallest squared
//   distance on the output channel (out_valid/out_ready). n = 0 gives no result.
//   Write entry_count (cfg_write_en/cfg_write_data) only while idle; unchecked.
// Timing:
//   A query reads one table entry per cycle from the table memory; in_ready
//   stays low while it runs and comes back in the same cycle that out_valid
//   rises. A load leaves in_ready high.
// Reset:
//   Clears control state and sets entry_count to MAX_ENTRIES. Table contents
//   are undefined until loaded; every scanned slot must have been loaded.
// Stall:
//   A result sits in the output register until taken; the block keeps taking
//   items meanwhile and only waits if a second result is ready before then.
// ----------------------------------------------------------------------------
module nearest_point_search
    import nps_pkg::*;
#(
    parameter int MAX_ENTRIES = NPS_MAX_ENTRIES,
    parameter int COORD_BITS  = NPS_COORD_BITS,
    localparam int IDX_W      = $clog2(MAX_ENTRIES),
    localparam int DIST_W     = 2 * COORD_BITS + 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_write_en,
    input  logic [NPS_COUNT_BITS-1:0]    cfg_write_data,
    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [IDX_W-1:0]             entry_index,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    // output channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [IDX_W-1:0]             nearest_index,
    output logic [DIST_W-1:0]            nearest_distance
);

    localparam int CNT_MAX   = (1 << NPS_COUNT_BITS) - 1;
    localparam int RESET_CNT = (MAX_ENTRIES > CNT_MAX) ? CNT_MAX : MAX_ENTRIES;
    localparam int EW        = (NPS_COUNT_BITS > IDX_W + 1) ? NPS_COUNT_BITS : IDX_W + 1;

    // table memory: {x, y} per slot, one write port, one registered read port
    logic [2*COORD_BITS-1:0] mem [MAX_ENTRIES];
    logic [2*COORD_BITS-1:0] rd_data_reg;
    logic                    mem_we;
    logic                    rd_en;

    nps_state_t              state_reg;
    nps_state_t              state_next;
    logic [NPS_COUNT_BITS-1:0] entry_count_reg;

    logic [COORD_BITS-1:0]   qx_reg;
    logic [COORD_BITS-1:0]   qy_reg;
    logic [IDX_W-1:0]        addr_reg;
    logic [IDX_W-1:0]        addr_next;
    logic [IDX_W-1:0]        last_reg;
    logic [IDX_W-1:0]        last_next;

    nps_tag_t                rd_tag;
    nps_tag_t                rd_tag_reg;
    logic [IDX_W-1:0]        rd_idx_reg;

    nps_tag_t                d_tag;
    logic [IDX_W-1:0]        d_idx;
    logic [DIST_W-1:0]       d_dist;

    logic                    have_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [DIST_W-1:0]       best_dist_reg;
    logic                    take_best;

    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic [DIST_W-1:0]       out_dist_reg;
    logic                    load_result;

    logic                    in_xfer;
    logic                    start_query;
    logic [EW-1:0]           cnt_ext;
    logic [EW-1:0]           n_eff;
    logic                    slot_ok;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // scan length: entry_count clamped to the table depth
    always_comb
    begin
        cnt_ext   = EW'(entry_count_reg);
        n_eff     = (cnt_ext > EW'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : cnt_ext;
        last_next = IDX_W'(n_eff - 1'b1);
        slot_ok   = ({1'b0, entry_index} < (IDX_W+1)'(MAX_ENTRIES));
    end

    assign start_query = in_xfer && (op == OP_QUERY) && (n_eff != '0);
    assign mem_we      = in_xfer && (op == OP_LOAD) && slot_ok;
    assign rd_en       = (state_reg == ST_SCAN);

    always_comb
    begin
        rd_tag.valid = rd_en;
        rd_tag.last  = rd_en && (addr_reg == last_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_count_reg <= NPS_COUNT_BITS'(RESET_CNT);
        else if (cfg_write_en)
            entry_count_reg <= cfg_write_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[entry_index] <= {coord_x, coord_y};
        if (rd_en)
            rd_data_reg <= mem[addr_reg];
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        load_result = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                addr_next = '0;
                if (start_query)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == last_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (d_tag.valid && d_tag.last)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_result = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            addr_reg   <= '0;
            rd_tag_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            rd_tag_reg <= rd_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= addr_reg;
        if (start_query)
        begin
            qx_reg   <= coord_x;
            qy_reg   <= coord_y;
            last_reg <= last_next;
        end
    end

    nps_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (rd_tag_reg),
        .in_index  (rd_idx_reg),
        .in_point  (rd_data_reg),
        .query_x   (qx_reg),
        .query_y   (qy_reg),
        .out_tag   (d_tag),
        .out_index (d_idx),
        .out_dist  (d_dist)
    );

    // running argmin; strict compare keeps the lowest slot on ties
    assign take_best = d_tag.valid && (!have_reg || (d_dist < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            have_reg <= 1'b0;
        else if (start_query)
            have_reg <= 1'b0;
        else if (d_tag.valid)
            have_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (take_best)
        begin
            best_idx_reg  <= d_idx;
            best_dist_reg <= d_dist;
        end
        if (load_result)
        begin
            out_idx_reg  <= best_idx_reg;
            out_dist_reg <= best_dist_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_result)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid        = out_valid_reg;
    assign nearest_index    = out_idx_reg;
    assign nearest_distance = out_dist_reg;

`ifndef ASSERT_OFF
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_tag_reg.valid && !d_tag.valid))
        else $error("distance pipe busy while idle");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (addr_reg <= last_reg))
        else $error("scan address past last slot");

    a_last_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (d_tag.valid && d_tag.last) |=> (state_reg == ST_RESULT))
        else $error("final entry did not close the query");

    a_result_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT) |-> have_reg)
        else $error("result without any scanned entry");
`endif

endmodule

[rtl/nps_dist.sv]
// ----------------------------------------------------------------------------
// nps_dist
// Three-stage squared distance pipe: difference/magnitude, square, sum.
// ----------------------------------------------------------------------------
module nps_dist
    import nps_pkg::*;
#(
    parameter int COORD_BITS = NPS_COORD_BITS,
    parameter int IDX_W      = 15,
    localparam int DIST_W    = 2 * COORD_BITS + 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  nps_tag_t                in_tag,
    input  logic [IDX_W-1:0]        in_index,
    input  logic [2*COORD_BITS-1:0] in_point,
    input  logic [COORD_BITS-1:0]   query_x,
    input  logic [COORD_BITS-1:0]   query_y,
    output nps_tag_t                out_tag,
    output logic [IDX_W-1:0]        out_index,
    output logic [DIST_W-1:0]       out_dist
);

    localparam int C = COORD_BITS;

    logic [C:0]       dx;
    logic [C:0]       dy;
    logic [C:0]       dx_abs;
    logic [C:0]       dy_abs;
    logic [C-1:0]     magx_reg;
    logic [C-1:0]     magy_reg;
    logic [2*C-1:0]   sqx_reg;
    logic [2*C-1:0]   sqy_reg;
    logic [2*C-1:0]   sqx_next;
    logic [2*C-1:0]   sqy_next;
    logic [DIST_W-1:0] sum_reg;
    nps_tag_t         tag1_reg;
    nps_tag_t         tag2_reg;
    nps_tag_t         tag3_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic [IDX_W-1:0] idx3_reg;

    // entry word is {x, y}; differences are taken one bit wider, sign-extended
    always_comb
    begin
        dx = {in_point[2*C-1], in_point[2*C-1:C]} - {query_x[C-1], query_x};
        dy = {in_point[C-1], in_point[C-1:0]} - {query_y[C-1], query_y};
        dx_abs = dx[C] ? (~dx + 1'b1) : dx;
        dy_abs = dy[C] ? (~dy + 1'b1) : dy;
        sqx_next = (2*C)'(magx_reg) * (2*C)'(magx_reg);
        sqy_next = (2*C)'(magy_reg) * (2*C)'(magy_reg);
    end

    always_ff @(posedge clk)
    begin
        magx_reg <= dx_abs[C-1:0];
        magy_reg <= dy_abs[C-1:0];
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        sum_reg  <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
        idx1_reg <= in_index;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign out_tag   = tag3_reg;
    assign out_index = idx3_reg;
    assign out_dist  = sum_reg;

endmodule
